FILE: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants and helpers for the environmental sensor compensation engine.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int unsigned DivSteps = 32;
	localparam int unsigned Latency  = 45;

	localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
	localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
	localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
	localparam logic [2:0] REG_CAL_MIXED   = 3'd3;
	localparam logic [2:0] REG_CAL_HUM     = 3'd4;

	localparam logic [31:0] K_64000     = 32'd64000;
	localparam logic [31:0] K_1048576   = 32'd1048576;
	localparam logic [31:0] K_3125      = 32'd3125;
	localparam logic [31:0] K_32768     = 32'd32768;
	localparam logic [31:0] K_76800     = 32'd76800;
	localparam logic [31:0] K_16384     = 32'd16384;
	localparam logic [31:0] K_2097152   = 32'd2097152;
	localparam logic [31:0] K_8192      = 32'd8192;
	localparam logic [31:0] K_HUM_MAX   = 32'd419430400;

	// arithmetic right shift of a 32-bit pattern
	function automatic logic [31:0] sar(input logic [31:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

endpackage

FILE: hdl/env_sensor_compensation.sv
// Each accepted triple reaches the done strobe at the end of the valid chain.
// Throughput: one raw triple per cycle, busy is never raised.
// Depth is set by the pressure divider, 32 pipelined restoring steps.
// Reset clears calibration registers to zero and empties the valid chain.
// Results are strobed by done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Pipelined fixed-point compensation of temperature, pressure and humidity.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [19:0]        adc_temp,
	input  logic [19:0]        adc_press,
	input  logic [15:0]        adc_hum,
	output logic               done,
	output logic signed [31:0] temp_centi,
	output logic [31:0]        press_pa,
	output logic [16:0]        hum_q10
);

	localparam int unsigned NDiv = esc_pkg::DivSteps;
	localparam int unsigned NLat = esc_pkg::Latency;

	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [47:0] cal_mixed_q;
	logic [31:0] cal_hum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q    <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_mixed_q   <= '0;
			cal_hum_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				esc_pkg::REG_CAL_TEMP:    cal_temp_q    <= cfg_wdata[47:0];
				esc_pkg::REG_CAL_PRESS_A: cal_press_a_q <= cfg_wdata;
				esc_pkg::REG_CAL_PRESS_B: cal_press_b_q <= cfg_wdata;
				esc_pkg::REG_CAL_MIXED:   cal_mixed_q   <= cfg_wdata[47:0];
				esc_pkg::REG_CAL_HUM:     cal_hum_q     <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] h1, h2, h3, h4, h5, h6;
	assign t1 = {16'b0, cal_temp_q[15:0]};
	assign t2 = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
	assign t3 = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
	assign p1 = {16'b0, cal_press_a_q[15:0]};
	assign p2 = {{16{cal_press_a_q[31]}}, cal_press_a_q[31:16]};
	assign p3 = {{16{cal_press_a_q[47]}}, cal_press_a_q[47:32]};
	assign p4 = {{16{cal_press_a_q[63]}}, cal_press_a_q[63:48]};
	assign p5 = {{16{cal_press_b_q[15]}}, cal_press_b_q[15:0]};
	assign p6 = {{16{cal_press_b_q[31]}}, cal_press_b_q[31:16]};
	assign p7 = {{16{cal_press_b_q[47]}}, cal_press_b_q[47:32]};
	assign p8 = {{16{cal_press_b_q[63]}}, cal_press_b_q[63:48]};
	assign p9 = {{16{cal_mixed_q[15]}}, cal_mixed_q[15:0]};
	assign h1 = {24'b0, cal_mixed_q[23:16]};
	assign h2 = {{16{cal_mixed_q[39]}}, cal_mixed_q[39:24]};
	assign h3 = {24'b0, cal_mixed_q[47:40]};
	assign h4 = {{20{cal_hum_q[11]}}, cal_hum_q[11:0]};
	assign h5 = {{20{cal_hum_q[23]}}, cal_hum_q[23:12]};
	assign h6 = {{24{cal_hum_q[31]}}, cal_hum_q[31:24]};

	assign busy = 1'b0;

	logic [NLat-1:0] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NLat-2:0], start && !busy};
		end
	end

	// front end
	logic [31:0] a1_s1, d2_s1;
	logic [19:0] ap_s [1:7];
	logic [15:0] ah_s [1:5];
	logic [31:0] v1t_s2, m3_s2, tf_s3;
	logic [31:0] temp_s4, pv1_s4, q_s4, vh_s4;
	logic [31:0] qq_s5, m5_s5, m6_s5, mh6_s5, mh3_s5, mh5_s5;
	logic [31:0] a6_s6, b6_s6, m5b_s6, m6_s6, x_s6, y1_s6;
	logic [31:0] v2_s7, v1b_s7, y2_s7, x_s7;
	logic [31:0] pv_s8, num_s8, y3_s8, x_s8;
	logic [31:0] den_s9, pn_s9, y_s9, x_s9;
	logic [31:0] hv_s10, hv_s11, hqq_s11, hv_s12, hr_s12;
	logic [16:0] hum_s13;

	logic [31:0] td_a, td_d, tf5, pv1_c, hx_c, hv13_c;
	assign td_a   = {15'b0, adc_temp[19:3]} - (t1 << 1);
	assign td_d   = {16'b0, adc_temp[19:4]} - t1;
	assign tf5    = (tf_s3 << 2) + tf_s3;
	assign pv1_c  = esc_pkg::sar(tf_s3, 1) - esc_pkg::K_64000;
	assign hx_c   = ({2'b0, ah_s[5], 14'b0} - (h4 << 20) - mh5_s5) + esc_pkg::K_16384;
	assign hv13_c = hv_s12 - esc_pkg::sar(hr_s12, 4);

	always_ff @(posedge clk) begin
		a1_s1   <= td_a * t2;
		d2_s1   <= td_d * td_d;
		ap_s[1] <= adc_press;
		ah_s[1] <= adc_hum;
		for (int i = 2; i <= 7; i++) ap_s[i] <= ap_s[i-1];
		for (int i = 2; i <= 5; i++) ah_s[i] <= ah_s[i-1];

		v1t_s2 <= esc_pkg::sar(a1_s1, 11);
		m3_s2  <= esc_pkg::sar(d2_s1, 12) * t3;
		tf_s3  <= v1t_s2 + esc_pkg::sar(m3_s2, 14);

		temp_s4 <= esc_pkg::sar(tf5 + 32'd128, 8);
		pv1_s4  <= pv1_c;
		q_s4    <= esc_pkg::sar(pv1_c, 2);
		vh_s4   <= tf_s3 - esc_pkg::K_76800;

		qq_s5  <= q_s4 * q_s4;
		m5_s5  <= pv1_s4 * p5;
		m6_s5  <= p2 * pv1_s4;
		mh6_s5 <= vh_s4 * h6;
		mh3_s5 <= vh_s4 * h3;
		mh5_s5 <= h5 * vh_s4;

		a6_s6  <= esc_pkg::sar(qq_s5, 11) * p6;
		b6_s6  <= p3 * esc_pkg::sar(qq_s5, 13);
		m5b_s6 <= m5_s5 << 1;
		m6_s6  <= m6_s5;
		x_s6   <= esc_pkg::sar(hx_c, 15);
		y1_s6  <= esc_pkg::sar(mh6_s5, 10) *
			(esc_pkg::sar(mh3_s5, 11) + esc_pkg::K_32768);

		v2_s7  <= esc_pkg::sar(a6_s6 + m5b_s6, 2) + (p4 << 16);
		v1b_s7 <= esc_pkg::sar(esc_pkg::sar(b6_s6, 3) + esc_pkg::sar(m6_s6, 1), 18);
		y2_s7  <= esc_pkg::sar(y1_s6, 10) + esc_pkg::K_2097152;
		x_s7   <= x_s6;

		pv_s8  <= (esc_pkg::K_32768 + v1b_s7) * p1;
		num_s8 <= (esc_pkg::K_1048576 - {12'b0, ap_s[7]}) - esc_pkg::sar(v2_s7, 12);
		y3_s8  <= y2_s7 * h2 + esc_pkg::K_8192;
		x_s8   <= x_s7;

		den_s9 <= esc_pkg::sar(pv_s8, 15);
		pn_s9  <= num_s8 * esc_pkg::K_3125;
		y_s9   <= esc_pkg::sar(y3_s8, 14);
		x_s9   <= x_s8;

		hv_s10  <= x_s9 * y_s9;
		hv_s11  <= hv_s10;
		hqq_s11 <= esc_pkg::sar(hv_s10, 15) * esc_pkg::sar(hv_s10, 15);
		hv_s12  <= hv_s11;
		hr_s12  <= esc_pkg::sar(hqq_s11, 7) * h1;
		if (hv13_c[31])
			hum_s13 <= '0;
		else if (hv13_c > esc_pkg::K_HUM_MAX)
			hum_s13 <= esc_pkg::K_HUM_MAX[28:12];
		else
			hum_s13 <= hv13_c[28:12];
	end

	// restoring divider, one quotient bit per stage
	logic [31:0] dn_s [0:NDiv];
	logic [31:0] dr_s [0:NDiv];
	logic [31:0] dq_s [0:NDiv];
	logic [31:0] dd_s [0:NDiv];
	logic        dz_s [0:NDiv];
	logic        dp_s [0:NDiv];
	logic [32:0] trial [0:NDiv-1];
	logic [32:0] diff  [0:NDiv-1];

	always_comb begin
		for (int j = 0; j < NDiv; j++) begin
			trial[j] = {dr_s[j], dn_s[j][31]};
			diff[j]  = trial[j] - {1'b0, dd_s[j]};
		end
	end

	always_ff @(posedge clk) begin
		dn_s[0] <= pn_s9[31] ? pn_s9 : (pn_s9 << 1);
		dr_s[0] <= '0;
		dq_s[0] <= '0;
		dd_s[0] <= den_s9;
		dz_s[0] <= (den_s9 == '0);
		dp_s[0] <= pn_s9[31];
		for (int j = 0; j < NDiv; j++) begin
			dn_s[j+1] <= dn_s[j] << 1;
			dd_s[j+1] <= dd_s[j];
			dz_s[j+1] <= dz_s[j];
			dp_s[j+1] <= dp_s[j];
			if (!diff[j][32]) begin
				dr_s[j+1] <= diff[j][31:0];
				dq_s[j+1] <= {dq_s[j][30:0], 1'b1};
			end else begin
				dr_s[j+1] <= trial[j][31:0];
				dq_s[j+1] <= {dq_s[j][30:0], 1'b0};
			end
		end
	end

	// pressure correction
	logic [31:0] pq_c;
	logic [31:0] p_s43, sq_s43, m8_s43, p_s44, w1m_s44, w2_s44;
	logic        z_s43, z_s44;
	assign pq_c = dp_s[NDiv] ? (dq_s[NDiv] << 1) : dq_s[NDiv];

	always_ff @(posedge clk) begin
		p_s43   <= pq_c;
		sq_s43  <= (pq_c >> 3) * (pq_c >> 3);
		m8_s43  <= (pq_c >> 2) * p8;
		z_s43   <= dz_s[NDiv];
		p_s44   <= p_s43;
		w1m_s44 <= p9 * (sq_s43 >> 13);
		w2_s44  <= esc_pkg::sar(m8_s43, 13);
		z_s44   <= z_s43;
		press_pa <= z_s44 ? '0 : p_s44 +
			esc_pkg::sar(esc_pkg::sar(w1m_s44, 12) + w2_s44 + p7, 4);
	end

	// alignment of temperature and humidity to the pressure result
	logic [31:0] tdl_s [0:NLat-5];
	logic [16:0] hdl_s [0:NLat-14];
	always_ff @(posedge clk) begin
		tdl_s[0] <= temp_s4;
		for (int i = 1; i <= NLat-5; i++) tdl_s[i] <= tdl_s[i-1];
		hdl_s[0] <= hum_s13;
		for (int i = 1; i <= NLat-14; i++) hdl_s[i] <= hdl_s[i-1];
	end

	assign temp_centi = $signed(tdl_s[NLat-5]);
	assign hum_q10    = hdl_s[NLat-14];
	assign done       = vld_s[NLat-1];

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hum_q10 <= 17'd102400))
		else $error("humidity out of range");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, NLat))
		else $error("result beat without matching input beat");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NLat-4] && dz_s[NDiv]) |=> ##2 (press_pa == 32'd0))
		else $error("zero divisor did not give zero pressure");

endmodule
